>>> hw/rtl/sscd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscd_pkg
// Shared constants, codes and types of the serial set-command decoder.
// ----------------------------------------------------------------------------
package sscd_pkg;

	// raw line length limit, bytes per line before overflow is LINE_CAPACITY-1
	localparam int LINE_CAPACITY = 64;
	localparam int RAW_W         = $clog2(LINE_CAPACITY);

	// normalized text tracking: six positions, only the first five are examined
	localparam int NORM_KEEP  = 6;
	localparam int NORM_STORE = 5;
	localparam int NORM_W     = $clog2(NORM_KEEP + 1);

	// status codes
	localparam logic [2:0] ST_SET_OK     = 3'd0;
	localparam logic [2:0] ST_BAD_SYNTAX = 3'd1;
	localparam logic [2:0] ST_BAD_TARGET = 3'd2;
	localparam logic [2:0] ST_BAD_CMD    = 3'd3;
	localparam logic [2:0] ST_OVERFLOW   = 3'd4;

	// target codes
	localparam logic [2:0] TGT_OUT1 = 3'd0;
	localparam logic [2:0] TGT_OUT2 = 3'd1;
	localparam logic [2:0] TGT_OUT3 = 3'd2;
	localparam logic [2:0] TGT_5V   = 3'd3;
	localparam logic [2:0] TGT_BLUE = 3'd4;
	localparam logic [2:0] TGT_RED  = 3'd5;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// normalized line snapshot
	typedef struct packed {
		logic                             overflowed;
		logic [NORM_W-1:0]                norm_count;
		logic [NORM_W-1:0]                text_end_pos;
		logic [NORM_STORE-1:0][7:0]       chars;
	} line_t;

	// decoded line end result
	typedef struct packed {
		logic       produce;
		logic [2:0] status;
		logic [2:0] target;
		logic       level;
	} res_t;

endpackage

>>> hw/rtl/sscd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscd_decode
// Classifies a finished normalized line into a status, target and level.
// ----------------------------------------------------------------------------
module sscd_decode (
	input  sscd_pkg::line_t line,
	output sscd_pkg::res_t  res
);

	logic [sscd_pkg::NORM_W-1:0] text_len;

	assign text_len = (line.text_end_pos < line.norm_count) ? line.text_end_pos
		: line.norm_count;

	always_comb begin
		res.produce = line.overflowed || (line.norm_count != '0);
		res.status  = sscd_pkg::ST_SET_OK;
		res.target  = sscd_pkg::TGT_OUT1;
		res.level   = 1'b0;
		if (line.overflowed) begin
			res.status = sscd_pkg::ST_OVERFLOW;
		end else if (line.chars[0] != sscd_pkg::CH_S) begin
			res.status = sscd_pkg::ST_BAD_CMD;
		end else if (text_len != sscd_pkg::NORM_W'(5)
				|| line.chars[1] != sscd_pkg::CH_SPACE
				|| line.chars[3] != sscd_pkg::CH_SPACE
				|| (line.chars[4] != sscd_pkg::CH_0 && line.chars[4] != sscd_pkg::CH_1)) begin
			res.status = sscd_pkg::ST_BAD_SYNTAX;
		end else begin
			res.level = (line.chars[4] == sscd_pkg::CH_1);
			case (line.chars[2])
				sscd_pkg::CH_1: res.target = sscd_pkg::TGT_OUT1;
				sscd_pkg::CH_2: res.target = sscd_pkg::TGT_OUT2;
				sscd_pkg::CH_3: res.target = sscd_pkg::TGT_OUT3;
				sscd_pkg::CH_5: res.target = sscd_pkg::TGT_5V;
				sscd_pkg::CH_B: res.target = sscd_pkg::TGT_BLUE;
				sscd_pkg::CH_R: res.target = sscd_pkg::TGT_RED;
				default: begin
					res.status = sscd_pkg::ST_BAD_TARGET;
					res.level  = 1'b0;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/serial_set_command_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_set_command_decoder_unit
// Line assembler and decoder for "S <target> <level>" serial commands.
// ----------------------------------------------------------------------------
// Each input beat carries one received byte. The byte is captured in an input
// register and is then folded into the line state (raw length, overflow flag,
// normalized first characters) by a single pass of logic; CR or LF ends the
// line and loads at most one result beat into the output register.
// Throughput is one byte per clock: a byte is held back only when it is a
// line end and the output register still holds an untaken result. A line-end
// byte passes through the input register, and its result beat is then loaded
// into the output register.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module serial_set_command_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	// byte input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	// result output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [2:0] target,
	output logic       level
);

	// input register
	logic                        valid_s1;
	logic [7:0]                  data_s1;

	// line state
	logic [sscd_pkg::RAW_W-1:0]  raw_count_q;
	logic                        space_pending_q;
	sscd_pkg::line_t             line_q;

	// next-state and decode
	logic [sscd_pkg::RAW_W-1:0]  raw_count_d;
	logic                        space_pending_d;
	sscd_pkg::line_t             line_d;
	sscd_pkg::res_t              res;
	logic                        is_eol;
	logic                        block;
	logic                        fire_s1;
	logic [7:0]                  upper;

	// output register
	logic                        out_valid_q;
	logic [2:0]                  status_q;
	logic [2:0]                  target_q;
	logic                        level_q;

	// add one character to the normalized text, saturating at six positions
	function automatic sscd_pkg::line_t append(input sscd_pkg::line_t l,
			input logic [7:0] c);
		sscd_pkg::line_t r;
		r = l;
		if (l.norm_count < sscd_pkg::NORM_W'(sscd_pkg::NORM_KEEP)) begin
			if (l.norm_count < sscd_pkg::NORM_W'(sscd_pkg::NORM_STORE))
				r.chars[l.norm_count] = c;
			if (c == sscd_pkg::CH_NUL
					&& l.text_end_pos == sscd_pkg::NORM_W'(sscd_pkg::NORM_KEEP))
				r.text_end_pos = l.norm_count;
			r.norm_count = l.norm_count + sscd_pkg::NORM_W'(1);
		end
		return r;
	endfunction

	assign is_eol  = (data_s1 == sscd_pkg::CH_CR) || (data_s1 == sscd_pkg::CH_LF);
	// a line end waits only while an untaken result sits in the output register
	assign block   = valid_s1 && is_eol && out_valid_q && out_stall;
	assign fire_s1 = valid_s1 && !block;
	assign in_stall = block;

	// fold a letter to upper case
	assign upper = (data_s1 inside {[sscd_pkg::CH_LOW_A:sscd_pkg::CH_LOW_Z]})
		? data_s1 - sscd_pkg::CASE_OFS : data_s1;

	sscd_decode u_decode (
		.line (line_q),
		.res  (res)
	);

	// per-byte line update
	always_comb begin
		raw_count_d     = raw_count_q;
		space_pending_d = space_pending_q;
		line_d          = line_q;
		if (is_eol) begin
			raw_count_d         = '0;
			space_pending_d     = 1'b0;
			line_d.overflowed   = 1'b0;
			line_d.norm_count   = '0;
			line_d.text_end_pos = sscd_pkg::NORM_W'(sscd_pkg::NORM_KEEP);
		end else if (!line_q.overflowed) begin
			if (raw_count_q == sscd_pkg::RAW_W'(sscd_pkg::LINE_CAPACITY - 1)) begin
				line_d.overflowed = 1'b1;
			end else begin
				raw_count_d = raw_count_q + sscd_pkg::RAW_W'(1);
				if (data_s1 == sscd_pkg::CH_SPACE || data_s1 == sscd_pkg::CH_TAB) begin
					// blanks only count once text has started
					space_pending_d = (line_q.norm_count != '0);
				end else begin
					if (space_pending_q)
						line_d = append(line_d, sscd_pkg::CH_SPACE);
					space_pending_d = 1'b0;
					line_d = append(line_d, upper);
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= '0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			data_s1  <= data_byte;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q     <= '0;
			space_pending_q <= 1'b0;
			line_q          <= '{overflowed: 1'b0, norm_count: '0,
				text_end_pos: sscd_pkg::NORM_W'(sscd_pkg::NORM_KEEP), chars: '0};
		end else if (fire_s1) begin
			raw_count_q     <= raw_count_d;
			space_pending_q <= space_pending_d;
			line_q          <= line_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= sscd_pkg::ST_SET_OK;
			target_q    <= sscd_pkg::TGT_OUT1;
			level_q     <= 1'b0;
		end else if (fire_s1 && is_eol && res.produce) begin
			out_valid_q <= 1'b1;
			status_q    <= res.status;
			target_q    <= res.target;
			level_q     <= res.level;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign target    = target_q;
	assign level     = level_q;

	// a new result never lands on a stalled one
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && is_eol && res.produce |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// a line end clears the raw count, normalized length, overflow flag and pending blank
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && is_eol |=> raw_count_q == '0 && line_q.norm_count == '0
			&& !line_q.overflowed && !space_pending_q)
		else $error("line state not cleared at line end");

	// normalized length saturates at six
	assert property (@(posedge clk) disable iff (!arst_n)
		line_q.norm_count <= sscd_pkg::NORM_W'(sscd_pkg::NORM_KEEP))
		else $error("normalized length beyond six");

	// raw length never passes the capacity limit
	assert property (@(posedge clk) disable iff (!arst_n)
		raw_count_q <= sscd_pkg::RAW_W'(sscd_pkg::LINE_CAPACITY - 1))
		else $error("raw length beyond capacity");

	// blank run pending only once text has started
	assert property (@(posedge clk) disable iff (!arst_n)
		space_pending_q |-> line_q.norm_count != '0)
		else $error("pending blank with no text");

endmodule
